>>> rtl/frit_pkg.sv
// ============================================================================
// frit_pkg: shared types and constants of the focus/rest interval timer
// Holds the command codes, end-plan choices, limits, register indexes and the
// structs that travel between the configuration block, the core and the queue.
// ============================================================================
package frit_pkg;

    localparam int MAX_ROUNDS        = 24;
    localparam int MAX_FOCUS_MINUTES = 120;
    localparam int MAX_REST_MINUTES  = 60;
    localparam int SECS_PER_MIN      = 60;

    localparam int SEC_W   = 13;
    localparam int ROUND_W = 5;
    localparam int FOCUS_W = 7;
    localparam int REST_W  = 6;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    localparam logic [FOCUS_W-1:0] FOCUS_RESET  = 7'd25;
    localparam logic [REST_W-1:0]  REST_RESET   = 6'd5;
    localparam logic [ROUND_W-1:0] ROUNDS_RESET = 5'd4;

    // Register indexes, taken from paddr[3:2].
    localparam logic [1:0] REG_FOCUS  = 2'd0;
    localparam logic [1:0] REG_REST   = 2'd1;
    localparam logic [1:0] REG_ROUNDS = 2'd2;

    typedef enum logic [2:0] {
        KIND_TICK      = 3'd0,
        KIND_START     = 3'd1,
        KIND_PAUSE     = 3'd2,
        KIND_RESUME    = 3'd3,
        KIND_END_FOCUS = 3'd4,
        KIND_SKIP_REST = 3'd5,
        KIND_END_PLAN  = 3'd6,
        KIND_RESET     = 3'd7
    } t_kind;

    localparam logic [1:0] CHOICE_RECORD  = 2'd0;
    localparam logic [1:0] CHOICE_DISCARD = 2'd1;
    localparam logic [1:0] CHOICE_CANCEL  = 2'd2;

    // Clamped phase lengths and round limit as the core uses them.
    typedef struct packed {
        logic [SEC_W-1:0]   focus_len;
        logic [SEC_W-1:0]   rest_len;
        logic [ROUND_W-1:0] rounds;
    } t_cfg_lens;

    typedef struct packed {
        logic [SEC_W-1:0]   remaining_seconds;
        logic [ROUND_W-1:0] round_number;
        logic               resting;
        logic               counting;
        logic               record_valid;
        logic [SEC_W-1:0]   record_seconds;
        logic               record_early;
        logic               plan_ended;
    } t_result;

endpackage

>>> rtl/frit_cfg.sv
// ============================================================================
// frit_cfg: configuration registers behind an APB-style port
// Stores focus length, rest length and round count, and derives the clamped
// phase lengths in seconds for the core.
// ============================================================================
module frit_cfg #(
    parameter int MAX_ROUNDS        = frit_pkg::MAX_ROUNDS,
    parameter int MAX_FOCUS_MINUTES = frit_pkg::MAX_FOCUS_MINUTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frit_pkg::ADDR_W-1:0]   paddr,
    input  logic [frit_pkg::DATA_W-1:0]   pwdata,
    output logic [frit_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output frit_pkg::t_cfg_lens           o_lens
);

    localparam int FocusCap  = (MAX_FOCUS_MINUTES > 127) ? 127 : MAX_FOCUS_MINUTES;
    localparam int RoundsCap = (MAX_ROUNDS > 31) ? 31 : MAX_ROUNDS;
    localparam logic [frit_pkg::FOCUS_W-1:0] FocusHi  = frit_pkg::FOCUS_W'(FocusCap);
    localparam logic [frit_pkg::REST_W-1:0]  RestHi   =
        frit_pkg::REST_W'(frit_pkg::MAX_REST_MINUTES);
    localparam logic [frit_pkg::ROUND_W-1:0] RoundsHi = frit_pkg::ROUND_W'(RoundsCap);
    localparam logic [frit_pkg::SEC_W-1:0]   SecsMin  = frit_pkg::SEC_W'(frit_pkg::SECS_PER_MIN);

    logic [frit_pkg::FOCUS_W-1:0] r_focus;
    logic [frit_pkg::REST_W-1:0]  r_rest;
    logic [frit_pkg::ROUND_W-1:0] r_rounds;
    logic [1:0]                   reg_sel;
    logic                         wr_en;
    logic [frit_pkg::FOCUS_W-1:0] focus_clamped;
    logic [frit_pkg::REST_W-1:0]  rest_clamped;

    assign reg_sel = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus  <= frit_pkg::FOCUS_RESET;
            r_rest   <= frit_pkg::REST_RESET;
            r_rounds <= frit_pkg::ROUNDS_RESET;
        end else if (wr_en) begin
            case (reg_sel)
                frit_pkg::REG_FOCUS:  r_focus  <= pwdata[frit_pkg::FOCUS_W-1:0];
                frit_pkg::REG_REST:   r_rest   <= pwdata[frit_pkg::REST_W-1:0];
                frit_pkg::REG_ROUNDS: r_rounds <= pwdata[frit_pkg::ROUND_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            frit_pkg::REG_FOCUS:  prdata = {{(frit_pkg::DATA_W-frit_pkg::FOCUS_W){1'b0}}, r_focus};
            frit_pkg::REG_REST:   prdata = {{(frit_pkg::DATA_W-frit_pkg::REST_W){1'b0}}, r_rest};
            frit_pkg::REG_ROUNDS: prdata = {{(frit_pkg::DATA_W-frit_pkg::ROUND_W){1'b0}}, r_rounds};
            default:              prdata = '0;
        endcase
    end

    always_comb begin
        if (r_focus == '0) begin
            focus_clamped = frit_pkg::FOCUS_W'(1);
        end else if (r_focus > FocusHi) begin
            focus_clamped = FocusHi;
        end else begin
            focus_clamped = r_focus;
        end

        if (r_rest == '0) begin
            rest_clamped = frit_pkg::REST_W'(1);
        end else if (r_rest > RestHi) begin
            rest_clamped = RestHi;
        end else begin
            rest_clamped = r_rest;
        end

        if (r_rounds == '0) begin
            o_lens.rounds = frit_pkg::ROUND_W'(1);
        end else if (r_rounds > RoundsHi) begin
            o_lens.rounds = RoundsHi;
        end else begin
            o_lens.rounds = r_rounds;
        end

        o_lens.focus_len = SecsMin * {{(frit_pkg::SEC_W-frit_pkg::FOCUS_W){1'b0}}, focus_clamped};
        o_lens.rest_len  = SecsMin * {{(frit_pkg::SEC_W-frit_pkg::REST_W){1'b0}}, rest_clamped};
    end

endmodule

>>> rtl/frit_core.sv
// ============================================================================
// frit_core: timer state and per-command update
// Applies one accepted command to the phase state and forms its result.
// ============================================================================
module frit_core (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_step,
    input  logic [2:0]            i_kind,
    input  logic [1:0]            i_end_choice,
    input  frit_pkg::t_cfg_lens   i_lens,
    output frit_pkg::t_result     o_result
);

    logic [frit_pkg::SEC_W-1:0]   r_sec, n_sec;
    logic [frit_pkg::ROUND_W-1:0] r_round, n_round;
    logic                         r_rest, n_rest;
    logic                         r_active, n_active;
    logic [frit_pkg::SEC_W-1:0]   focused;
    logic [frit_pkg::SEC_W-1:0]   sec_dec;
    logic                         more_rounds;
    frit_pkg::t_kind              kind;

    assign kind        = frit_pkg::t_kind'(i_kind);
    assign focused     = (i_lens.focus_len > r_sec) ? i_lens.focus_len - r_sec : '0;
    assign sec_dec     = (r_sec != '0) ? r_sec - frit_pkg::SEC_W'(1) : '0;
    assign more_rounds = r_round < i_lens.rounds;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec    <= '0;
            r_round  <= '0;
            r_rest   <= 1'b0;
            r_active <= 1'b0;
        end else if (i_step) begin
            r_sec    <= n_sec;
            r_round  <= n_round;
            r_rest   <= n_rest;
            r_active <= n_active;
        end
    end

    always_comb begin
        logic fin;
        logic go_rest;
        logic go_focus;
        fin      = 1'b0;
        go_rest  = 1'b0;
        go_focus = 1'b0;
        n_sec    = r_sec;
        n_round  = r_round;
        n_rest   = r_rest;
        n_active = r_active;
        o_result.record_valid   = 1'b0;
        o_result.record_seconds = '0;
        o_result.record_early   = 1'b0;

        case (kind)
            frit_pkg::KIND_TICK: begin
                if (r_active) begin
                    n_sec = sec_dec;
                    if (sec_dec == '0) begin
                        n_active = 1'b0;
                        if (!r_rest) begin
                            o_result.record_valid   = 1'b1;
                            o_result.record_seconds = i_lens.focus_len;
                            go_rest = more_rounds;
                        end else begin
                            go_focus = more_rounds;
                        end
                        fin = !more_rounds;
                    end
                end
            end
            frit_pkg::KIND_START: begin
                n_round  = frit_pkg::ROUND_W'(1);
                n_rest   = 1'b0;
                n_sec    = i_lens.focus_len;
                n_active = 1'b1;
            end
            frit_pkg::KIND_PAUSE: begin
                n_active = 1'b0;
            end
            frit_pkg::KIND_RESUME: begin
                if (r_sec != '0 && r_round != '0) begin
                    n_active = 1'b1;
                end
            end
            frit_pkg::KIND_END_FOCUS: begin
                if (r_round != '0 && !r_rest) begin
                    if (focused != '0) begin
                        o_result.record_valid   = 1'b1;
                        o_result.record_seconds = focused;
                        o_result.record_early   = 1'b1;
                    end
                    n_active = 1'b0;
                    go_rest  = more_rounds;
                    fin      = !more_rounds;
                end
            end
            frit_pkg::KIND_SKIP_REST: begin
                if (r_round != '0 && r_rest) begin
                    n_active = 1'b0;
                    go_focus = more_rounds;
                    fin      = !more_rounds;
                end
            end
            frit_pkg::KIND_END_PLAN: begin
                if (r_round != '0) begin
                    fin = 1'b1;
                    if (!r_rest && focused != '0) begin
                        if (i_end_choice == frit_pkg::CHOICE_CANCEL) begin
                            fin = 1'b0;
                        end else if (i_end_choice == frit_pkg::CHOICE_RECORD) begin
                            o_result.record_valid   = 1'b1;
                            o_result.record_seconds = focused;
                            o_result.record_early   = 1'b1;
                        end
                    end
                end
            end
            frit_pkg::KIND_RESET: begin
                n_active = 1'b0;
                n_round  = '0;
                n_rest   = 1'b0;
                n_sec    = i_lens.focus_len;
            end
            default: ;
        endcase

        // Phase transitions shared by several commands.
        if (go_rest) begin
            n_rest   = 1'b1;
            n_sec    = i_lens.rest_len;
            n_active = 1'b1;
        end
        if (go_focus) begin
            n_round  = r_round + frit_pkg::ROUND_W'(1);
            n_rest   = 1'b0;
            n_sec    = i_lens.focus_len;
            n_active = 1'b1;
        end
        if (fin) begin
            n_active = 1'b0;
            n_sec    = '0;
            n_round  = '0;
            n_rest   = 1'b0;
        end

        o_result.plan_ended        = fin;
        o_result.remaining_seconds = n_sec;
        o_result.round_number      = n_round;
        o_result.resting           = n_rest;
        o_result.counting          = n_active;
    end

endmodule

>>> rtl/frit_outq.sv
// ============================================================================
// frit_outq: two-entry result queue
// Holds finished results so the input side keeps flowing while the output
// side stalls, until both entries are occupied.
// ============================================================================
module frit_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  frit_pkg::t_result  i_data,
    output logic               o_not_full,
    output logic               o_valid,
    input  logic               i_pop_ready,
    output frit_pkg::t_result  o_data
);

    frit_pkg::t_result r_mem [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;
    logic              pop;

    assign o_not_full = r_count != 2'd2;
    assign o_valid    = r_count != 2'd0;
    assign pop        = o_valid & i_pop_ready;
    assign o_data     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/focus_rest_interval_timer.sv
// ============================================================================
// focus_rest_interval_timer: focus/rest countdown over a set number of rounds
// Top level: configuration port, command core and result queue.
// ============================================================================
// Every accepted command (a one-second tick, start, pause, resume, end focus,
// skip rest, end plan or reset) produces exactly one result, and the block
// takes one command per clock cycle: the core updates its state in the cycle
// of acceptance and writes the result into a two-entry output queue, so a new
// command is taken even while one result waits to be read, and input ready
// drops only when both queue entries are occupied. Each result is written
// into the output queue and shown once the results ahead of it are read.
// Phase lengths come from the focus and rest registers in minutes, clamped
// to their legal ranges and scaled to seconds; the round count is clamped
// the same way. Registers are written through the APB-style port and
// should only change while the timer has no results pending.
module focus_rest_interval_timer #(
    parameter int MAX_ROUNDS        = frit_pkg::MAX_ROUNDS,
    parameter int MAX_FOCUS_MINUTES = frit_pkg::MAX_FOCUS_MINUTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,

    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [2:0]                    i_kind,
    input  logic [1:0]                    i_end_choice,

    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [frit_pkg::SEC_W-1:0]    o_remaining_seconds,
    output logic [frit_pkg::ROUND_W-1:0]  o_round_number,
    output logic                          o_resting,
    output logic                          o_counting,
    output logic                          o_record_valid,
    output logic [frit_pkg::SEC_W-1:0]    o_record_seconds,
    output logic                          o_record_early,
    output logic                          o_plan_ended,

    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [frit_pkg::ADDR_W-1:0]   paddr,
    input  logic [frit_pkg::DATA_W-1:0]   pwdata,
    output logic [frit_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    frit_pkg::t_cfg_lens lens;
    frit_pkg::t_result   core_result;
    frit_pkg::t_result   out_result;
    logic                step;

    // A command transaction completes when valid meets a free queue slot.
    assign step = i_in_valid & o_in_ready;

    frit_cfg #(
        .MAX_ROUNDS        (MAX_ROUNDS),
        .MAX_FOCUS_MINUTES (MAX_FOCUS_MINUTES)
    ) u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_lens  (lens)
    );

    frit_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_kind       (i_kind),
        .i_end_choice (i_end_choice),
        .i_lens       (lens),
        .o_result     (core_result)
    );

    frit_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (step),
        .i_data      (core_result),
        .o_not_full  (o_in_ready),
        .o_valid     (o_out_valid),
        .i_pop_ready (i_out_ready),
        .o_data      (out_result)
    );

    // Unpack the queued result onto the individual output ports.
    assign o_remaining_seconds = out_result.remaining_seconds;
    assign o_round_number      = out_result.round_number;
    assign o_resting           = out_result.resting;
    assign o_counting          = out_result.counting;
    assign o_record_valid      = out_result.record_valid;
    assign o_record_seconds    = out_result.record_seconds;
    assign o_record_early      = out_result.record_early;
    assign o_plan_ended        = out_result.plan_ended;

endmodule
